// ===== sv/rc4_pkg.sv =====
// Shared types and constants of the RC4 stream cipher core.
`timescale 1ns / 1ps

package rc4_pkg;

	localparam int BYTE_W          = 8;
	localparam int PERM_DEPTH      = 256;
	localparam int PERM_AW         = 8;
	localparam int KEY_STORE_DEPTH = 256;
	localparam int CMD_W           = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT = 2'd0,
		CMD_KEY  = 2'd1,
		CMD_DATA = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic               clr;
		logic               we;
		logic [PERM_AW-1:0] waddr;
		logic [BYTE_W-1:0]  wdata;
		logic [PERM_AW-1:0] raddr;
	} perm_req_t;

endpackage

// ===== sv/rc4_perm_mem.sv =====
// Permutation memory: one write and one read port, registered read, per-entry valid bits.
`timescale 1ns / 1ps

module rc4_perm_mem (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  rc4_pkg::perm_req_t                      req,
	output logic [rc4_pkg::BYTE_W-1:0]              rdata
);

	logic [rc4_pkg::BYTE_W-1:0]  mem [rc4_pkg::PERM_DEPTH];
	logic [rc4_pkg::PERM_DEPTH-1:0] vld_q;
	logic [rc4_pkg::BYTE_W-1:0]  data_q;
	logic [rc4_pkg::PERM_AW-1:0] addr_q;
	logic                        hit_q;

	// entries not written since init read as their own index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			hit_q <= (req.we && req.waddr == req.raddr) || vld_q[req.raddr];
		end
	end

	// write-first on a same-address read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.we && req.waddr == req.raddr) begin
			data_q <= req.wdata;
		end else begin
			data_q <= mem[req.raddr];
		end
		addr_q <= req.raddr;
	end

	assign rdata = hit_q ? data_q : addr_q;

endmodule

// ===== sv/rc4_key_mem.sv =====
// Key store memory: one write and one read port, registered read.
`timescale 1ns / 1ps

module rc4_key_mem #(
	parameter int DEPTH = rc4_pkg::KEY_STORE_DEPTH,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [rc4_pkg::BYTE_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [rc4_pkg::BYTE_W-1:0] rdata
);

	logic [rc4_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [rc4_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/rc4_keyed_stream_cipher_core.sv =====
// Top level of the RC4 keyed stream cipher core: command sequencer and output register.
//
// Usage:
//   Input words arrive on s_*: s_tuser carries the command (init, key byte,
//   data byte, no-op), s_tdata the byte, s_tlast marks the final key byte.
//   Cipher bytes leave on m_*, one for each data command, in order.
//   Every swap step of the key schedule and of the keystream runs through the
//   single read port of the permutation memory: read S[i], read S[j], write
//   S[i], write S[j] while the next read is issued.
//   Init: valid bits of the permutation are cleared at once.
//   Key byte: states IDLE, RDJ, SWPI, SWPJ; the final key byte repeats RDJ, SWPI
//   and SWPJ for each of the remaining schedule steps until the mixing index wraps.
//   Data byte: states IDLE, RDJ, SWPI, SWPJ, OUT; result registered in the output stage.
//   No-op: taken in IDLE with no further step.
//   Reset loads the identity permutation immediately; no sweep is needed.
//   The output register holds a word while m_tready is low; further commands
//   are still taken, and a data command waits in its last cycle until the
//   output register is free.
`timescale 1ns / 1ps

module rc4_keyed_stream_cipher_core #(
	parameter int KEY_STORE_DEPTH = rc4_pkg::KEY_STORE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] byte_value
	input  logic       s_tlast,   // last_key_byte
	input  logic [1:0] s_tuser,   // [1:0] command
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [7:0] cipher_byte
);

	localparam int KCNT_W = $clog2(KEY_STORE_DEPTH + 1);
	localparam int KIDX_W = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
	localparam int BW     = rc4_pkg::BYTE_W;
	localparam int AW     = rc4_pkg::PERM_AW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDJ,
		ST_SWPI,
		ST_SWPJ,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic                in_run_q;
	logic [AW-1:0]       mix_q;
	logic [AW-1:0]       j_q;
	logic [AW-1:0]       oidx_q;
	logic [AW-1:0]       idx_q;
	logic [KCNT_W-1:0]   pos_q;
	logic [KCNT_W-1:0]   len_q;
	logic [KCNT_W-1:0]   rp_q;
	logic                data_q;
	logic                first_q;
	logic                last_q;
	logic [BW-1:0]       val_q;
	logic [BW-1:0]       si_q;
	logic [AW-1:0]       t_q;
	logic                out_vld_q;
	logic [BW-1:0]       out_q;

	rc4_pkg::perm_req_t  preq;
	logic [BW-1:0]       perm_rd;
	logic [BW-1:0]       key_rd;
	logic                kwe;
	logic                kre;

	rc4_pkg::cmd_t       cmd;
	logic                acc;
	logic [AW-1:0]       i_eff;
	logic [KCNT_W-1:0]   pos_eff;
	logic                store_ok;
	logic [BW-1:0]       k;
	logic [AW-1:0]       j_new;
	logic [AW-1:0]       mix_next;
	logic                cont;
	logic [KCNT_W-1:0]   rp_inc;
	logic                out_free;

	assign cmd      = rc4_pkg::cmd_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign i_eff    = in_run_q ? mix_q : '0;
	assign pos_eff  = in_run_q ? pos_q : '0;
	assign store_ok = pos_eff < KCNT_W'(KEY_STORE_DEPTH);
	assign k        = data_q ? '0 : (first_q ? val_q : key_rd);
	assign j_new    = j_q + perm_rd + k;
	assign mix_next = mix_q + 1'b1;
	assign cont     = !data_q && last_q && (mix_next != '0);
	assign rp_inc   = rp_q + 1'b1;
	assign out_free = !out_vld_q || m_tready;

	rc4_perm_mem u_perm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (preq),
		.rdata  (perm_rd)
	);

	rc4_key_mem #(
		.DEPTH (KEY_STORE_DEPTH)
	) u_key (
		.clk   (clk),
		.we    (kwe),
		.waddr (pos_eff[KIDX_W-1:0]),
		.wdata (s_tdata),
		.re    (kre),
		.raddr (rp_q[KIDX_W-1:0]),
		.rdata (key_rd)
	);

	always_comb begin
		preq = '0;
		kwe  = 1'b0;
		kre  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (cmd)
						rc4_pkg::CMD_INIT: preq.clr = 1'b1;
						rc4_pkg::CMD_KEY: begin
							preq.raddr = i_eff;
							kwe        = store_ok;
						end
						rc4_pkg::CMD_DATA: preq.raddr = oidx_q + 1'b1;
						default: ;
					endcase
				end
			end
			ST_RDJ: preq.raddr = j_new;
			ST_SWPI: begin
				preq.we    = 1'b1;
				preq.waddr = idx_q;
				preq.wdata = perm_rd;
			end
			ST_SWPJ: begin
				preq.we    = 1'b1;
				preq.waddr = j_q;
				preq.wdata = si_q;
				preq.raddr = data_q ? t_q : mix_next;
				kre        = cont;
			end
			// keep the keystream byte on the read port while the output stalls
			ST_OUT: preq.raddr = t_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			in_run_q  <= 1'b0;
			mix_q     <= '0;
			j_q       <= '0;
			oidx_q    <= '0;
			idx_q     <= '0;
			pos_q     <= '0;
			len_q     <= '0;
			rp_q      <= '0;
			data_q    <= 1'b0;
			first_q   <= 1'b0;
			last_q    <= 1'b0;
			val_q     <= '0;
			si_q      <= '0;
			t_q       <= '0;
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_q     <= val_q ^ perm_rd;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (cmd)
							rc4_pkg::CMD_INIT: begin
								j_q      <= '0;
								in_run_q <= 1'b0;
								mix_q    <= '0;
								pos_q    <= '0;
								len_q    <= '0;
							end
							rc4_pkg::CMD_KEY: begin
								in_run_q <= 1'b1;
								mix_q    <= i_eff;
								idx_q    <= i_eff;
								if (store_ok) begin
									pos_q <= pos_eff + 1'b1;
									len_q <= pos_eff + 1'b1;
								end else begin
									pos_q <= pos_eff;
								end
								rp_q    <= '0;
								data_q  <= 1'b0;
								first_q <= 1'b1;
								last_q  <= s_tlast;
								val_q   <= s_tdata;
								state_q <= ST_RDJ;
							end
							rc4_pkg::CMD_DATA: begin
								oidx_q  <= oidx_q + 1'b1;
								idx_q   <= oidx_q + 1'b1;
								data_q  <= 1'b1;
								val_q   <= s_tdata;
								state_q <= ST_RDJ;
							end
							default: ;
						endcase
					end
				end
				ST_RDJ: begin
					si_q    <= perm_rd;
					j_q     <= j_new;
					state_q <= ST_SWPI;
				end
				ST_SWPI: begin
					t_q     <= si_q + perm_rd;
					state_q <= ST_SWPJ;
				end
				ST_SWPJ: begin
					if (data_q) begin
						state_q <= ST_OUT;
					end else begin
						mix_q <= mix_next;
						if (cont) begin
							idx_q   <= mix_next;
							first_q <= 1'b0;
							rp_q    <= (rp_inc >= len_q) ? '0 : rp_inc;
							state_q <= ST_RDJ;
						end else begin
							if (last_q) begin
								oidx_q   <= '0;
								in_run_q <= 1'b0;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule

// ===== verif/rc4_keyed_stream_cipher_checker.sv =====
// Checker for the RC4 core: tracks cipher state from input words and checks output words.
`timescale 1ns / 1ps

module rc4_keyed_stream_cipher_checker
	import rc4_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] byte_value
	input  logic       s_tlast,   // last_key_byte
	input  logic [1:0] s_tuser,   // [1:0] command
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] cipher_byte
	output int         errors,
	output int         pending,
	output int         checked
);

	logic [7:0]  sbox [PERM_DEPTH];
	logic [7:0]  key_mem [KEY_STORE_DEPTH];
	int unsigned key_len;
	int unsigned key_pos;
	logic [7:0]  ksa_i;
	logic [7:0]  j_idx;
	logic [7:0]  prga_i;
	bit          key_open;
	logic [7:0]  cipher_q [$];
	logic [7:0]  cipher_exp;
	int          err_n;
	int          chk_n;

	initial begin
		errors  = 0;
		pending = 0;
		checked = 0;
		err_n   = 0;
		chk_n   = 0;
	end

	function void load_identity();
		for (int n = 0; n < PERM_DEPTH; n++)
			sbox[n] = 8'(n);
		j_idx = '0;
	endfunction

	function void swap_sbox(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] t;
		t       = sbox[a];
		sbox[a] = sbox[b];
		sbox[b] = t;
	endfunction

	function void ksa_step(input logic [7:0] k);
		j_idx = j_idx + sbox[ksa_i] + k;
		swap_sbox(ksa_i, j_idx);
		ksa_i = ksa_i + 8'd1;
	endfunction

	function void absorb_word(input cmd_t cmd, input logic [7:0] val, input logic last);
		int unsigned pos;
		logic [7:0]  sum;
		case (cmd)
			CMD_INIT: begin
				load_identity();
				key_open = 1'b0;
				ksa_i    = '0;
				key_pos  = 0;
				key_len  = 0;
			end
			CMD_KEY: begin
				if (!key_open) begin
					key_open = 1'b1;
					ksa_i    = '0;
					key_pos  = 0;
					key_len  = 0;
				end
				if (key_pos < KEY_STORE_DEPTH) begin
					key_mem[key_pos] = val;
					key_pos++;
					key_len = key_pos;
				end
				ksa_step(val);
				if (last) begin
					// finish the schedule by cycling over the stored key
					pos = 0;
					while (ksa_i != 8'd0) begin
						if (pos >= key_len)
							pos = 0;
						ksa_step(key_mem[pos]);
						pos++;
					end
					prga_i   = '0;
					key_open = 1'b0;
				end
			end
			CMD_DATA: begin
				prga_i = prga_i + 8'd1;
				j_idx  = j_idx + sbox[prga_i];
				swap_sbox(prga_i, j_idx);
				sum = sbox[prga_i] + sbox[j_idx];
				cipher_q.push_back(val ^ sbox[sum]);
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_identity();
			key_len  = 0;
			key_pos  = 0;
			ksa_i    = '0;
			prga_i   = '0;
			key_open = 1'b0;
			cipher_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (cipher_q.size() == 0) begin
					if (err_n < 10)
						$display("%0t: unexpected output word %02h", $realtime, m_tdata);
					err_n++;
				end else begin
					cipher_exp = cipher_q.pop_front();
					chk_n++;
					if (m_tdata !== cipher_exp) begin
						if (err_n < 10)
							$display("%0t: cipher byte mismatch: expected %02h, got %02h",
								$realtime, cipher_exp, m_tdata);
						err_n++;
					end
				end
			end
			if (s_tvalid && s_tready)
				absorb_word(cmd_t'(s_tuser), s_tdata, s_tlast);
		end
		errors  <= err_n;
		pending <= cipher_q.size();
		checked <= chk_n;
	end

endmodule

// ===== verif/rc4_keyed_stream_cipher_core_tb.sv =====
// Testbench top for the RC4 core: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module rc4_keyed_stream_cipher_core_tb;
	import rc4_pkg::*;

	localparam int NUM_WORDS   = 1800;
	localparam int DRAIN_CYCLES = 1000;
	localparam int CYCLE_LIMIT = 2_000_000;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = '0;   // [7:0] byte_value
	logic       s_tlast  = 1'b0; // last_key_byte
	logic [1:0] s_tuser  = CMD_NOP; // [1:0] command
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;         // [7:0] cipher_byte

	int errors;
	int pending;
	int checked;
	int words_sent = 0;
	int key_runs   = 0;
	int burst_left = 0;
	int cycle_count = 0;
	int stall_left = 0;
	int stall_mode = 0;

	rc4_keyed_stream_cipher_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rc4_keyed_stream_cipher_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
			$display("** rc4_keyed_stream_cipher_core: FAILED **");
			$finish;
		end
	end

	// receiver: always ready, random, sparse, or fully stalled stretches
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = (stall_mode == 3) ? $urandom_range(5, 40) : $urandom_range(20, 300);
		end
		stall_left--;
		case (stall_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= 1'($urandom_range(0, 1));
			2:       m_tready <= (stall_left % 5 == 0);
			default: m_tready <= 1'b0;
		endcase
	end

	task automatic send_word(input cmd_t cmd, input logic [7:0] val, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= val;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		if (cmd != CMD_NOP)
			words_sent++;
	endtask

	task automatic key_run(input int unsigned len);
		for (int unsigned n = 0; n < len; n++) begin
			if ($urandom_range(0, 9) == 0)
				send_word(CMD_DATA, 8'($urandom), 1'($urandom_range(0, 1)));
			send_word(CMD_KEY, 8'($urandom), n == len - 1);
		end
		key_runs++;
	endtask

	task automatic send_plain(input logic [7:0] text []);
		foreach (text[n])
			send_word(CMD_DATA, text[n], 1'b0);
	endtask

	initial begin
		int unsigned pick;
		int unsigned len;
		logic [7:0]  plain [];

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// keystream from the identity permutation, ignored commands and marks
		send_word(CMD_DATA, 8'h00, 1'b0);
		send_word(CMD_DATA, 8'hFF, 1'b1);
		send_word(CMD_NOP, 8'hFF, 1'b1);
		send_word(CMD_INIT, 8'hFF, 1'b1);
		// classic vector: key "Key", text "Plaintext"
		send_word(CMD_KEY, 8'h4B, 1'b0);
		send_word(CMD_KEY, 8'h65, 1'b0);
		send_word(CMD_KEY, 8'h79, 1'b1);
		plain = '{8'h50, 8'h6C, 8'h61, 8'h69, 8'h6E, 8'h74, 8'h65, 8'h78, 8'h74};
		send_plain(plain);
		// data in the middle of a run, then init abandons the run
		send_word(CMD_INIT, 8'h00, 1'b0);
		send_word(CMD_KEY, 8'h00, 1'b0);
		send_word(CMD_KEY, 8'hFF, 1'b0);
		send_word(CMD_DATA, 8'hA5, 1'b0);
		send_word(CMD_INIT, 8'h00, 1'b0);
		send_word(CMD_KEY, 8'hFF, 1'b1);
		// second run with no init in between
		send_word(CMD_KEY, 8'h00, 1'b1);
		send_word(CMD_DATA, 8'h3C, 1'b0);
		send_word(CMD_NOP, 8'h00, 1'b0);
		key_runs += 4;

		while (words_sent < NUM_WORDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				if ($urandom_range(0, 1))
					send_word(CMD_INIT, 8'($urandom), 1'($urandom_range(0, 1)));
				pick = $urandom_range(0, 99);
				if (pick < 5)
					len = $urandom_range(240, 300);
				else if (pick < 20)
					len = $urandom_range(17, 64);
				else
					len = $urandom_range(1, 16);
				key_run(len);
				repeat ($urandom_range(1, 40))
					send_word(CMD_DATA, 8'($urandom), 1'($urandom_range(0, 1)));
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 20))
					send_word(CMD_DATA, 8'($urandom), 1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(1, 8))
					send_word(cmd_t'($urandom_range(0, 3)), 8'($urandom),
						1'($urandom_range(0, 1)));
			end
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d words in %0d key runs plus data and noise, %0d cipher bytes checked",
			words_sent, key_runs, checked);
		$display("sender bursts and receiver stalls mixed, %0d mismatches", errors);
		if (errors == 0 && pending == 0)
			$display("** rc4_keyed_stream_cipher_core: PASSED **");
		else
			$display("** rc4_keyed_stream_cipher_core: FAILED **");
		$finish;
	end

endmodule
